FILE: rtl/psq_pkg.sv
// Shared types, codes, field offsets and reset values of the priority queue manager.
`default_nettype none

package psq_pkg;

    localparam int NUM_QUEUES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 256;

    localparam int QIDX_W   = 3;
    localparam int HANDLE_W = 16;
    localparam int LEN_W    = 14;
    localparam int BYTES_W  = 25;
    localparam int TOTAL_W  = 28;
    localparam int DESC_W   = HANDLE_W + LEN_W;

    // Input transaction: tuser carries the operation, tdata the rest.
    localparam int OP_W          = 2;
    localparam int IN_QIDX_LSB   = 0;
    localparam int IN_HANDLE_LSB = IN_QIDX_LSB + QIDX_W;
    localparam int IN_LEN_LSB    = IN_HANDLE_LSB + HANDLE_W;
    localparam int IN_PAUSE_LSB  = IN_LEN_LSB + LEN_W;
    localparam int IN_DATA_W     = 40;

    // Result transaction layout in tdata, lowest field first.
    localparam int OUT_ACC_LSB    = 0;
    localparam int OUT_DV_LSB     = 1;
    localparam int OUT_HANDLE_LSB = 2;
    localparam int OUT_LEN_LSB    = OUT_HANDLE_LSB + HANDLE_W;
    localparam int OUT_QUEUE_LSB  = OUT_LEN_LSB + LEN_W;
    localparam int OUT_TOTAL_LSB  = OUT_QUEUE_LSB + QIDX_W;
    localparam int OUT_QBYTES_LSB = OUT_TOTAL_LSB + TOTAL_W;
    localparam int OUT_QPAUSE_LSB = OUT_QBYTES_LSB + BYTES_W;
    localparam int OUT_EMPTY_LSB  = OUT_QPAUSE_LSB + 1;
    localparam int OUT_USED_W     = OUT_EMPTY_LSB + 1;
    localparam int OUT_DATA_W     = 96;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE   = 2'd0,
        OP_DEQUEUE   = 2'd1,
        OP_SET_PAUSE = 2'd2,
        OP_QUERY     = 2'd3
    } op_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 25;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIMITED_QUEUE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PACKETS   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BYTE_LIMIT    = 2'd2;

    localparam int MAX_PKTS_W = 9;
    localparam logic [QIDX_W-1:0]     LIMITED_QUEUE_RST = 3'd1;
    localparam logic [MAX_PKTS_W-1:0] MAX_PACKETS_RST   = 9'd2;
    localparam logic [BYTES_W-1:0]    BYTE_LIMIT_RST    = 25'h1000000;

endpackage

`default_nettype wire

FILE: rtl/pausable_strict_priority_queues.sv
// Top level of the strict-priority descriptor queue manager with per-queue pause.
//
// Usage: one input transaction on s_axis carries an operation in tuser (enqueue,
// dequeue, set pause, query) and its arguments in tdata. Each input transaction
// produces exactly one result transaction on m_axis carrying the accept/dequeue
// flags, the dequeued descriptor and occupancy figures after the operation.
// Configuration registers (limited queue, its packet cap, per-queue byte limit)
// are written on the cfg channel, which is always ready.
// Operation flow: one operation is in work at a time. Enqueue, set pause and query
// pass through S_EXEC and S_REPORT; a dequeue that finds a packet also passes
// through S_RDATA, because the descriptor comes out of the synchronous descriptor
// memory as a registered read issued in S_EXEC. The next input is taken in the
// cycle after the result register is loaded.
// Reset clears all counters, pointers, pause flags and the result register and
// loads the configuration defaults; the descriptor memory is not cleared.
// When the receiver stalls, the result stays registered; a following item is
// still accepted and worked up to its result, where it waits for the register.
`default_nettype none

module pausable_strict_priority_queues #(
    parameter int NUM_QUEUES  = psq_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = psq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata: queue_index[2:0], packet_handle[18:3], packet_bytes[32:19], pause_value[33]
    input  wire logic [psq_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // tuser: op[1:0]
    input  wire logic [psq_pkg::OP_W-1:0]            s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // tdata: enqueue_accepted[0], dequeue_valid[1], out_handle[17:2], out_bytes[31:18],
    // out_queue[34:32], total_bytes[62:35], indexed_queue_bytes[87:63],
    // indexed_queue_paused[88], all_empty[89]
    output logic [psq_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [psq_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [psq_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int QW        = $clog2(NUM_QUEUES);
    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam int HW  = psq_pkg::HANDLE_W;
    localparam int LW  = psq_pkg::LEN_W;
    localparam int BW  = psq_pkg::BYTES_W;
    localparam int TW  = psq_pkg::TOTAL_W;
    localparam int IQW = psq_pkg::QIDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RDATA,
        S_REPORT
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [IQW-1:0]                  limited_queue_reg;
    logic [psq_pkg::MAX_PKTS_W-1:0]  max_packets_reg;
    logic [BW-1:0]                   byte_limit_reg;

    // Latched input transaction.
    psq_pkg::op_t   op_reg;
    logic [IQW-1:0] qidx_reg;
    logic [HW-1:0]  handle_reg;
    logic [LW-1:0]  len_reg;
    logic           pause_val_reg;

    // Per-queue state.
    logic [PTR_W-1:0] head_reg  [NUM_QUEUES];
    logic [PTR_W-1:0] tail_reg  [NUM_QUEUES];
    logic [CNT_W-1:0] count_reg [NUM_QUEUES];
    logic [BW-1:0]    bytes_reg [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] pause_reg;
    logic [TW-1:0]    total_reg;

    // Result being assembled.
    logic          acc_reg;
    logic          dv_reg;
    logic [HW-1:0] out_handle_reg;
    logic [LW-1:0] out_len_reg;
    logic [QW-1:0] deq_q_reg;

    logic                              m_valid_reg;
    logic [psq_pkg::OUT_DATA_W-1:0]    m_data_reg;

    // Descriptor memory.
    logic [psq_pkg::DESC_W-1:0] desc_mem [MEM_DEPTH];
    logic [psq_pkg::DESC_W-1:0] rd_data_reg;
    logic                       mem_we;
    logic                       mem_re;
    logic [ADDR_W-1:0]          mem_addr;

    logic          in_accept;
    logic          out_free;
    logic [QW-1:0] q_idx;
    logic          q_in_range;
    logic [QW-1:0] sel_q;
    logic          sel_found;
    logic [QW-1:0] cur_q;
    logic [PTR_W-1:0] head_cur;
    logic [PTR_W-1:0] tail_cur;
    logic [CNT_W-1:0] count_cur;
    logic [BW-1:0]    bytes_cur;
    logic             pause_cur;
    logic [BW:0]      bytes_sum;
    logic             enq_ok;
    logic             any_held;
    logic [LW-1:0]    rd_len;
    logic [BW-1:0]    dec_bytes;
    logic [psq_pkg::OUT_USED_W-1:0] result;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign cfg_ready     = 1'b1;

    assign q_idx      = QW'(qidx_reg);
    assign q_in_range = 32'(qidx_reg) < NUM_QUEUES;

    // Lowest-numbered queue that holds a packet and is not paused.
    always_comb
    begin
        sel_q     = '0;
        sel_found = 1'b0;
        for (int i = NUM_QUEUES - 1; i >= 0; i--)
        begin
            if (!pause_reg[i] && (count_reg[i] != '0))
            begin
                sel_q     = QW'(i);
                sel_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        any_held = 1'b0;
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            any_held = any_held | (count_reg[i] != '0);
        end
    end

    // The operation reads the per-queue arrays at a single queue index in each state.
    always_comb
    begin
        case (state_reg)
            S_EXEC:  cur_q = (op_reg == psq_pkg::OP_DEQUEUE) ? sel_q : q_idx;
            S_RDATA: cur_q = deq_q_reg;
            default: cur_q = q_idx;
        endcase
    end

    assign head_cur  = head_reg[cur_q];
    assign tail_cur  = tail_reg[cur_q];
    assign count_cur = count_reg[cur_q];
    assign bytes_cur = bytes_reg[cur_q];
    assign pause_cur = pause_reg[cur_q];

    assign bytes_sum = {1'b0, bytes_cur} + (BW + 1)'(len_reg);
    assign enq_ok    = q_in_range
                    && !((qidx_reg == limited_queue_reg)
                         && (32'(count_cur) >= 32'(max_packets_reg)))
                    && (bytes_sum <= {1'b0, byte_limit_reg})
                    && (32'(count_cur) < QUEUE_DEPTH);

    assign rd_len    = rd_data_reg[LW-1:0];
    assign dec_bytes = (bytes_cur >= BW'(rd_len)) ? BW'(rd_len) : bytes_cur;

    assign mem_we   = (state_reg == S_EXEC) && (op_reg == psq_pkg::OP_ENQUEUE) && enq_ok;
    assign mem_re   = (state_reg == S_EXEC) && (op_reg == psq_pkg::OP_DEQUEUE) && sel_found;
    assign mem_addr = ADDR_W'(32'(cur_q) * QUEUE_DEPTH
                              + 32'(mem_we ? tail_cur : head_cur));

    always_comb
    begin
        result = '0;
        result[psq_pkg::OUT_ACC_LSB]                 = acc_reg;
        result[psq_pkg::OUT_DV_LSB]                  = dv_reg;
        result[psq_pkg::OUT_HANDLE_LSB +: HW]        = out_handle_reg;
        result[psq_pkg::OUT_LEN_LSB +: LW]           = out_len_reg;
        result[psq_pkg::OUT_QUEUE_LSB +: IQW]        = IQW'(deq_q_reg) & {IQW{dv_reg}};
        result[psq_pkg::OUT_TOTAL_LSB +: TW]         = total_reg;
        result[psq_pkg::OUT_QBYTES_LSB +: BW]        = q_in_range ? bytes_cur : '0;
        result[psq_pkg::OUT_QPAUSE_LSB]              = q_in_range && pause_cur;
        result[psq_pkg::OUT_EMPTY_LSB]               = !any_held;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            desc_mem[mem_addr] <= {handle_reg, len_reg};
        end
        if (mem_re)
        begin
            rd_data_reg <= desc_mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limited_queue_reg <= psq_pkg::LIMITED_QUEUE_RST;
            max_packets_reg   <= psq_pkg::MAX_PACKETS_RST;
            byte_limit_reg    <= psq_pkg::BYTE_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                psq_pkg::CFG_LIMITED_QUEUE: limited_queue_reg <= cfg_data[IQW-1:0];
                psq_pkg::CFG_MAX_PACKETS:
                    max_packets_reg <= cfg_data[psq_pkg::MAX_PKTS_W-1:0];
                psq_pkg::CFG_BYTE_LIMIT:    byte_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
            op_reg         <= psq_pkg::OP_ENQUEUE;
            qidx_reg       <= '0;
            handle_reg     <= '0;
            len_reg        <= '0;
            pause_val_reg  <= 1'b0;
            pause_reg      <= '0;
            total_reg      <= '0;
            acc_reg        <= 1'b0;
            dv_reg         <= 1'b0;
            deq_q_reg      <= '0;
            out_handle_reg <= '0;
            out_len_reg    <= '0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
                bytes_reg[i] <= '0;
            end
        end
        else
        begin
            // In S_REPORT the result register is handled by the state itself.
            if (m_valid_reg && m_axis_tready && (state_reg != S_REPORT))
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        op_reg         <= psq_pkg::op_t'(s_axis_tuser);
                        qidx_reg       <= s_axis_tdata[psq_pkg::IN_QIDX_LSB +: IQW];
                        handle_reg     <= s_axis_tdata[psq_pkg::IN_HANDLE_LSB +: HW];
                        len_reg        <= s_axis_tdata[psq_pkg::IN_LEN_LSB +: LW];
                        pause_val_reg  <= s_axis_tdata[psq_pkg::IN_PAUSE_LSB];
                        acc_reg        <= 1'b0;
                        dv_reg         <= 1'b0;
                        deq_q_reg      <= '0;
                        out_handle_reg <= '0;
                        out_len_reg    <= '0;
                        state_reg      <= S_EXEC;
                    end
                end

                S_EXEC:
                begin
                    state_reg <= S_REPORT;
                    case (op_reg)
                        psq_pkg::OP_ENQUEUE:
                        begin
                            if (enq_ok)
                            begin
                                acc_reg          <= 1'b1;
                                tail_reg[cur_q]  <= (tail_cur == PTR_W'(QUEUE_DEPTH - 1))
                                                    ? '0 : tail_cur + 1'b1;
                                count_reg[cur_q] <= count_cur + 1'b1;
                                bytes_reg[cur_q] <= bytes_sum[BW-1:0];
                                total_reg        <= total_reg + TW'(len_reg);
                            end
                        end
                        psq_pkg::OP_DEQUEUE:
                        begin
                            if (sel_found)
                            begin
                                dv_reg           <= 1'b1;
                                deq_q_reg        <= sel_q;
                                head_reg[cur_q]  <= (head_cur == PTR_W'(QUEUE_DEPTH - 1))
                                                    ? '0 : head_cur + 1'b1;
                                count_reg[cur_q] <= count_cur - 1'b1;
                                state_reg        <= S_RDATA;
                            end
                        end
                        psq_pkg::OP_SET_PAUSE:
                        begin
                            if (q_in_range)
                            begin
                                pause_reg[cur_q] <= pause_val_reg;
                            end
                        end
                        default: ;
                    endcase
                end

                S_RDATA:
                begin
                    // Descriptor read issued in the previous cycle is now registered.
                    out_handle_reg   <= rd_data_reg[psq_pkg::DESC_W-1:LW];
                    out_len_reg      <= rd_len;
                    bytes_reg[cur_q] <= bytes_cur - dec_bytes;
                    total_reg        <= total_reg - TW'(dec_bytes);
                    state_reg        <= S_REPORT;
                end

                S_REPORT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= psq_pkg::OUT_DATA_W'(result);
                        state_reg   <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/psq_checker.sv
// Port-level assertion checker for the priority queue manager, bound to the top level.
`default_nettype none

module psq_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [psq_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    logic acc;
    logic dv;
    logic empty;
    logic [psq_pkg::TOTAL_W-1:0] total;
    logic [psq_pkg::OUT_TOTAL_LSB-psq_pkg::OUT_HANDLE_LSB-1:0] desc_fields;

    assign acc         = m_axis_tdata[psq_pkg::OUT_ACC_LSB];
    assign dv          = m_axis_tdata[psq_pkg::OUT_DV_LSB];
    assign empty       = m_axis_tdata[psq_pkg::OUT_EMPTY_LSB];
    assign total       = m_axis_tdata[psq_pkg::OUT_TOTAL_LSB +: psq_pkg::TOTAL_W];
    assign desc_fields = m_axis_tdata[psq_pkg::OUT_TOTAL_LSB-1:psq_pkg::OUT_HANDLE_LSB];

    // A stalled result transaction holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result transaction changed while stalled");

    // One operation cannot both store and yield a packet.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(acc && dv))
        else $error("enqueue_accepted and dequeue_valid both set");

    // Without a dequeued packet the descriptor fields read as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !dv |-> desc_fields == '0)
        else $error("descriptor fields nonzero without dequeue_valid");

    // Empty queues hold no bytes, and a stored packet leaves them nonempty.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && empty |-> total == '0 && !acc)
        else $error("all_empty inconsistent with byte total or accept");

endmodule

bind pausable_strict_priority_queues psq_checker u_psq_checker (.*);

`default_nettype wire

FILE: bench/pausable_strict_priority_queues_test.sv
// Self-checking testbench for the strict-priority descriptor queue manager with pause.
`timescale 1ns / 100ps

module pausable_strict_priority_queues_test;

    localparam int NQ    = psq_pkg::NUM_QUEUES_DEF;
    localparam int DEPTH = psq_pkg::QUEUE_DEPTH_DEF;
    localparam int QW    = psq_pkg::QIDX_W;
    localparam int HW    = psq_pkg::HANDLE_W;
    localparam int LW    = psq_pkg::LEN_W;

    // Tracks every queue the way the block should and holds the status it owes.
    class port_queue_tracker;

        typedef struct packed {
            logic                         acc;
            logic                         dv;
            logic [HW-1:0]                handle;
            logic [LW-1:0]                len;
            logic [QW-1:0]                queue;
            logic [psq_pkg::TOTAL_W-1:0]  total;
            logic [psq_pkg::BYTES_W-1:0]  qbytes;
            logic                         qpaused;
            logic                         empty;
        } status_t;

        logic [HW-1:0]       slot_handle [NQ][DEPTH];
        logic [LW-1:0]       slot_len    [NQ][DEPTH];
        int unsigned         head [NQ];
        int unsigned         tail [NQ];
        int unsigned         held [NQ];
        int unsigned         qbytes [NQ];
        bit                  paused [NQ];
        int unsigned         lim_q;
        int unsigned         lim_max;
        int unsigned         byte_cap;
        status_t             owed_status [$];
        int                  errors;
        int                  seen;

        function new();
            for (int i = 0; i < NQ; i++)
            begin
                head[i]   = 0;
                tail[i]   = 0;
                held[i]   = 0;
                qbytes[i] = 0;
                paused[i] = 0;
            end
            lim_q    = psq_pkg::LIMITED_QUEUE_RST;
            lim_max  = psq_pkg::MAX_PACKETS_RST;
            byte_cap = psq_pkg::BYTE_LIMIT_RST;
            errors   = 0;
            seen     = 0;
        endfunction

        function void set_register(logic [psq_pkg::CFG_INDEX_W-1:0] idx,
                                   logic [psq_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                psq_pkg::CFG_LIMITED_QUEUE: lim_q    = val[QW-1:0];
                psq_pkg::CFG_MAX_PACKETS:   lim_max  = val[psq_pkg::MAX_PKTS_W-1:0];
                psq_pkg::CFG_BYTE_LIMIT:    byte_cap = val[psq_pkg::BYTES_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_status.size();
        endfunction

        // Applies one accepted operation and queues the status it must produce.
        function void take_operation(psq_pkg::op_t op, logic [QW-1:0] q, logic [HW-1:0] h,
                                     logic [LW-1:0] b, logic pv);
            status_t     s;
            int unsigned sum;
            s = '0;
            case (op)
                psq_pkg::OP_ENQUEUE:
                begin
                    if (!(q == lim_q && held[q] >= lim_max) && qbytes[q] + b <= byte_cap
                        && held[q] < DEPTH)
                    begin
                        slot_handle[q][tail[q]] = h;
                        slot_len[q][tail[q]]    = b;
                        tail[q]   = (tail[q] + 1) % DEPTH;
                        held[q]   = held[q] + 1;
                        qbytes[q] = qbytes[q] + b;
                        s.acc     = 1'b1;
                    end
                end
                psq_pkg::OP_DEQUEUE:
                begin
                    for (int i = 0; i < NQ; i++)
                    begin
                        if (!s.dv && !paused[i] && held[i] != 0)
                        begin
                            s.dv      = 1'b1;
                            s.handle  = slot_handle[i][head[i]];
                            s.len     = slot_len[i][head[i]];
                            s.queue   = QW'(i);
                            head[i]   = (head[i] + 1) % DEPTH;
                            held[i]   = held[i] - 1;
                            qbytes[i] = (qbytes[i] >= s.len) ? qbytes[i] - s.len : 0;
                        end
                    end
                end
                psq_pkg::OP_SET_PAUSE: paused[q] = pv;
                default: ;
            endcase
            sum     = 0;
            s.empty = 1'b1;
            for (int i = 0; i < NQ; i++)
            begin
                sum += qbytes[i];
                if (held[i] != 0)
                    s.empty = 1'b0;
            end
            s.total   = sum[psq_pkg::TOTAL_W-1:0];
            s.qbytes  = psq_pkg::BYTES_W'(qbytes[q]);
            s.qpaused = paused[q];
            owed_status = {owed_status, s};
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            errors++;
            if (errors <= 40)
                $display("result %0d: %s is %0h, expected %0h", seen, what, got, want);
        endtask

        task compare(string what, longint unsigned got, longint unsigned want);
            if (got != want)
                report(what, got, want);
        endtask

        task check_status(logic [psq_pkg::OUT_DATA_W-1:0] d);
            status_t e;
            seen++;
            if (owed_status.size() == 0)
            begin
                report("transaction with no operation outstanding",
                       64'(d[psq_pkg::OUT_USED_W-1:0]), 0);
                return;
            end
            e = owed_status.pop_front();
            compare("enqueue_accepted", d[psq_pkg::OUT_ACC_LSB], e.acc);
            compare("dequeue_valid", d[psq_pkg::OUT_DV_LSB], e.dv);
            compare("out_handle", d[psq_pkg::OUT_HANDLE_LSB +: HW], e.handle);
            compare("out_bytes", d[psq_pkg::OUT_LEN_LSB +: LW], e.len);
            compare("out_queue", d[psq_pkg::OUT_QUEUE_LSB +: QW], e.queue);
            compare("total_bytes", d[psq_pkg::OUT_TOTAL_LSB +: psq_pkg::TOTAL_W], e.total);
            compare("indexed_queue_bytes", d[psq_pkg::OUT_QBYTES_LSB +: psq_pkg::BYTES_W],
                    e.qbytes);
            compare("indexed_queue_paused", d[psq_pkg::OUT_QPAUSE_LSB], e.qpaused);
            compare("all_empty", d[psq_pkg::OUT_EMPTY_LSB], e.empty);
        endtask

    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [psq_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [psq_pkg::OP_W-1:0]        s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [psq_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [psq_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [psq_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    port_queue_tracker tracker = new();
    int idle_mode = 1;

    pausable_strict_priority_queues u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic int pick_wait();
        case (idle_mode)
            0:       return 0;
            2:       return $urandom_range(0, 2);
            default: return $urandom_range(0, 11);
        endcase
    endfunction

    // Result side: check each accepted transaction, then stall for a random count.
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                tracker.check_status(m_axis_tdata);
                stall = pick_wait();
            end
            if (stall > 0)
            begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Valid stays high into the next transaction when no gap is drawn.
    task automatic put(psq_pkg::op_t op, logic [QW-1:0] q, logic [HW-1:0] h,
                       logic [LW-1:0] b, logic pv);
        int gap;
        gap = pick_wait();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'b0, pv, b, h, q};
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.take_operation(op, q, h, b, pv);
    endtask

    task automatic put_noise_args(psq_pkg::op_t op, logic [QW-1:0] q, logic pv);
        put(op, q, HW'($urandom_range(0, 65535)), LW'($urandom_range(0, 16383)), pv);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_registers(int unsigned lq, int unsigned max_pkts, int unsigned cap);
        logic [psq_pkg::CFG_INDEX_W-1:0] idx [3];
        logic [psq_pkg::CFG_DATA_W-1:0]  val [3];
        idx[0] = psq_pkg::CFG_LIMITED_QUEUE;
        idx[1] = psq_pkg::CFG_MAX_PACKETS;
        idx[2] = psq_pkg::CFG_BYTE_LIMIT;
        val[0] = psq_pkg::CFG_DATA_W'(lq);
        val[1] = psq_pkg::CFG_DATA_W'(max_pkts);
        val[2] = psq_pkg::CFG_DATA_W'(cap);
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            tracker.set_register(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_traffic(int n);
        int            r;
        psq_pkg::op_t  op;
        logic [LW-1:0] b;
        for (int k = 0; k < n; k++)
        begin
            if (k % 40 == 0)
                idle_mode = $urandom_range(0, 2);
            r = $urandom_range(0, 99);
            if (r < 45)
                op = psq_pkg::OP_ENQUEUE;
            else if (r < 80)
                op = psq_pkg::OP_DEQUEUE;
            else if (r < 90)
                op = psq_pkg::OP_SET_PAUSE;
            else
                op = psq_pkg::OP_QUERY;
            r = $urandom_range(0, 9);
            if (r == 0)
                b = '0;
            else if (r == 1)
                b = 14'h3FFF;
            else if (r < 6)
                b = LW'($urandom_range(0, 16383));
            else
                b = LW'($urandom_range(1, 2000));
            // Pause writes lean toward releasing so that dequeues keep finding work.
            put(op, QW'($urandom_range(0, NQ - 1)), HW'($urandom_range(0, 65535)), b,
                $urandom_range(0, 2) == 0);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening under the reset configuration (queue 1 capped at two).
        idle_mode = 1;
        put_noise_args(psq_pkg::OP_QUERY, 3'd0, 1'b1);
        put_noise_args(psq_pkg::OP_DEQUEUE, 3'd5, 1'b0);
        put(psq_pkg::OP_ENQUEUE, 3'd0, 16'hFFFF, 14'h3FFF, 1'b1);
        put(psq_pkg::OP_ENQUEUE, 3'd0, 16'h0000, 14'h0000, 1'b0);
        put(psq_pkg::OP_ENQUEUE, 3'd1, 16'h0001, 14'd100, 1'b0);
        put(psq_pkg::OP_ENQUEUE, 3'd1, 16'h0002, 14'd200, 1'b1);
        put(psq_pkg::OP_ENQUEUE, 3'd1, 16'h0003, 14'd300, 1'b0);
        put(psq_pkg::OP_ENQUEUE, 3'd7, 16'hAAAA, 14'h2AAA, 1'b0);
        put(psq_pkg::OP_ENQUEUE, 3'd6, 16'h5555, 14'h1555, 1'b1);
        put_noise_args(psq_pkg::OP_SET_PAUSE, 3'd0, 1'b1);
        put_noise_args(psq_pkg::OP_QUERY, 3'd0, 1'b0);
        put_noise_args(psq_pkg::OP_DEQUEUE, 3'd2, 1'b1);
        put_noise_args(psq_pkg::OP_SET_PAUSE, 3'd1, 1'b1);
        put_noise_args(psq_pkg::OP_SET_PAUSE, 3'd6, 1'b1);
        put_noise_args(psq_pkg::OP_SET_PAUSE, 3'd7, 1'b1);
        // Every non-empty queue is paused here, so nothing is served.
        put_noise_args(psq_pkg::OP_DEQUEUE, 3'd4, 1'b0);
        put_noise_args(psq_pkg::OP_SET_PAUSE, 3'd0, 1'b0);
        put_noise_args(psq_pkg::OP_DEQUEUE, 3'd3, 1'b1);
        put_noise_args(psq_pkg::OP_DEQUEUE, 3'd0, 1'b0);
        put_noise_args(psq_pkg::OP_SET_PAUSE, 3'd1, 1'b0);
        put_noise_args(psq_pkg::OP_SET_PAUSE, 3'd6, 1'b0);
        put_noise_args(psq_pkg::OP_SET_PAUSE, 3'd7, 1'b0);
        put_noise_args(psq_pkg::OP_DEQUEUE, 3'd1, 1'b1);
        put_noise_args(psq_pkg::OP_DEQUEUE, 3'd6, 1'b0);
        put_noise_args(psq_pkg::OP_DEQUEUE, 3'd7, 1'b1);
        drain();

        // Limited queue refuses everything.
        write_registers($urandom_range(0, 7), 0, psq_pkg::BYTE_LIMIT_RST);
        random_traffic(80);
        drain();

        // No byte room at all: only zero-length packets get in.
        write_registers(7, 256, 0);
        random_traffic(80);
        drain();

        write_registers(0, $urandom_range(1, 8), 30000);
        random_traffic(80);
        drain();

        write_registers($urandom_range(0, 7), $urandom_range(0, 256),
                        $urandom_range(0, psq_pkg::BYTE_LIMIT_RST));
        random_traffic(80);
        drain();

        // Fill the lowest priority queue past its store depth.
        write_registers(0, 256, psq_pkg::BYTE_LIMIT_RST);
        idle_mode = 2;
        for (int i = 0; i < NQ; i++)
            put_noise_args(psq_pkg::OP_SET_PAUSE, QW'(i), 1'b0);
        for (int i = 0; i < DEPTH + 6; i++)
        begin
            if (i % 50 == 0)
                idle_mode = $urandom_range(0, 2);
            put_noise_args(psq_pkg::OP_ENQUEUE, QW'(NQ - 1), 1'($urandom_range(0, 1)));
        end
        drain();

        write_registers(psq_pkg::LIMITED_QUEUE_RST, psq_pkg::MAX_PACKETS_RST,
                        psq_pkg::BYTE_LIMIT_RST);
        random_traffic(100);
        drain();

        if (tracker.errors == 0)
            $display("pausable_strict_priority_queues_test: done, clean");
        else
            $display("pausable_strict_priority_queues_test: done, errors");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("pausable_strict_priority_queues_test: done, errors");
        $finish;
    end

endmodule
